// ----- src/evad_pkg.sv -----
package evad_pkg;

    localparam int unsigned MUL_W          = 32;
    localparam int unsigned PROD_W         = 2 * MUL_W;
    localparam int unsigned MANT_W         = 31;
    localparam int unsigned FRAC_W         = 16;
    localparam int unsigned CFG_IDX_W      = 2;
    localparam int unsigned CFG_DATA_W     = 16;

    localparam logic [31:0] TEN_LOG10_2_Q16 = 32'd197283;
    localparam int unsigned LG_OFFSET       = 30 * 65536;
    localparam logic [63:0] ROUND_HALF      = 64'd1 << 23;
    localparam logic [39:0] LVL_FLOOR_MAG   = 40'd30720;
    localparam logic [15:0] LVL_FLOOR       = 16'hFFFF - 16'd30720 + 16'd1;
    localparam logic [15:0] RUN_MAX         = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_RUN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_RUN   = 2'd2;

    localparam logic [15:0] THRESHOLD_RST = 16'hFFFF - 16'd10240 + 16'd1;
    localparam logic [15:0] START_RUN_RST = 16'd3;
    localparam logic [15:0] END_RUN_RST   = 16'd10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_NORM,
        ST_FMUL,
        ST_FSTEP,
        ST_LOGDONE,
        ST_SCALE,
        ST_ROUND,
        ST_DECIDE
    } t_evad_state;

    typedef struct packed {
        logic        pend;
        logic [15:0] level;
    } t_evad_frame;

    typedef struct packed {
        logic speech;
        logic flipped;
    } t_evad_dec;

endpackage

// ----- src/evad_in_if.sv -----
interface evad_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               frame_end;
    logic               discontinuity;

    modport source (output valid, sample, frame_end, discontinuity, input ready);
    modport sink   (input valid, sample, frame_end, discontinuity, output ready);
endinterface

// ----- src/evad_out_if.sv -----
interface evad_out_if;
    logic               valid;
    logic               ready;
    logic               speech_active;
    logic signed [15:0] frame_level;
    logic               state_flipped;

    modport source (output valid, speech_active, frame_level, state_flipped, input ready);
    modport sink   (input valid, speech_active, frame_level, state_flipped, output ready);
endinterface

// ----- src/evad_mul.sv -----
module evad_mul
    import evad_pkg::*;
(
    input  logic              i_clk,
    input  logic [MUL_W-1:0]  i_a,
    input  logic [MUL_W-1:0]  i_b,
    output logic [PROD_W-1:0] o_p
);

    logic [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// ----- src/evad_hyst.sv -----
module evad_hyst
    import evad_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_evad_frame           i_frame,
    input  logic                  i_upd,
    output t_evad_dec             o_dec
);

    logic [15:0] r_thr;
    logic [15:0] r_start;
    logic [15:0] r_end;
    logic        r_speech;
    logic [15:0] r_loud;
    logic [15:0] r_quiet;

    logic        n_speech;
    logic [15:0] n_loud;
    logic [15:0] n_quiet;
    logic        sm0;
    logic [15:0] lr0;
    logic [15:0] qr0;
    logic        is_loud;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= THRESHOLD_RST;
            r_start  <= START_RUN_RST;
            r_end    <= END_RUN_RST;
            r_speech <= 1'b0;
            r_loud   <= '0;
            r_quiet  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_THRESHOLD: r_thr   <= i_cfg_data;
                    CFG_START_RUN: r_start <= i_cfg_data;
                    CFG_END_RUN:   r_end   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_upd) begin
                r_speech <= n_speech;
                r_loud   <= n_loud;
                r_quiet  <= n_quiet;
            end
        end
    end

    always_comb begin
        sm0      = i_frame.pend ? 1'b0 : r_speech;
        lr0      = i_frame.pend ? 16'd0 : r_loud;
        qr0      = i_frame.pend ? 16'd0 : r_quiet;
        is_loud  = $signed(i_frame.level) >= $signed(r_thr);
        n_speech = sm0;
        o_dec.flipped = 1'b0;
        if (is_loud) begin
            n_loud  = (lr0 != RUN_MAX) ? lr0 + 16'd1 : lr0;
            n_quiet = '0;
            if (!sm0 && n_loud >= r_start) begin
                n_speech      = 1'b1;
                o_dec.flipped = 1'b1;
            end
        end else begin
            n_quiet = (qr0 != RUN_MAX) ? qr0 + 16'd1 : qr0;
            n_loud  = '0;
            if (sm0 && n_quiet >= r_end) begin
                n_speech      = 1'b0;
                o_dec.flipped = 1'b1;
            end
        end
        o_dec.speech = n_speech;
    end

endmodule

// ----- src/energy_voice_activity_detector.sv -----
// Channel       | Direction | Payload
// i_sample_ch   | in        | sample (s16), frame_end, discontinuity
// o_result_ch   | out       | speech_active, frame_level (s16 Q8 dB), state_flipped
// i_cfg_*       | in        | threshold_level, start_run_frames, end_run_frames
//
// A sample that does not end a frame passes through the accept, square and accumulate steps.
// A frame-ending sample adds two base-2 logarithm passes on the shared multiplier, each
// made of one-bit normalisation shifts, repeated squaring of the mantissa and a finishing step,
// then scaling, rounding and decision; an all-zero frame goes straight to decision.
// Reset is synchronous and clears the detector state, energy sum and sample count.
// A waiting result holds the decision step, and no request is taken until it has been taken.
module energy_voice_activity_detector
    import evad_pkg::*;
#(
    parameter int unsigned MAX_FRAME_SAMPLES = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    evad_in_if.sink               i_sample_ch,
    evad_out_if.source            o_result_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int unsigned SUM_W = CNT_W + 30;
    localparam int unsigned K_W   = $clog2(SUM_W);
    localparam int unsigned LG_W  = K_W + FRAC_W;
    localparam int unsigned D_W   = LG_W + 3;

    t_evad_state r_state;
    t_evad_state n_state;

    logic signed [15:0] r_sample;
    logic               r_fend;
    logic               r_pend;
    logic [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_n;
    logic [SUM_W-1:0]   r_x;
    logic [K_W-1:0]     r_k;
    logic [K_W-1:0]     r_e;
    logic [MANT_W-1:0]  r_m;
    logic [FRAC_W-1:0]  r_frac;
    logic [3:0]         r_it;
    logic               r_pass;
    logic [LG_W-1:0]    r_lga;
    logic [MUL_W-1:0]   r_t;
    logic [15:0]        r_level;
    logic               r_ovalid;
    logic               r_ospeech;
    logic               r_oflip;
    logic [15:0]        r_olevel;

    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [PROD_W-1:0]  prod;
    logic [16:0]        abs_s;
    logic [SUM_W-1:0]   sum_new;
    logic [CNT_W-1:0]   cnt_new;
    logic               frame_done;
    logic [LG_W-1:0]    lg_cur;
    logic signed [D_W-1:0] d_val;
    logic [D_W-1:0]     d_neg;
    logic [PROD_W-1:0]  rounded;
    logic [39:0]        mag;
    logic               accept;
    logic               load_out;
    logic               take_out;
    t_evad_frame        frame;
    t_evad_dec          dec;

    evad_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign frame.pend  = r_pend;
    assign frame.level = r_level;

    evad_hyst u_hyst (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_frame    (frame),
        .i_upd      (load_out),
        .o_dec      (dec)
    );

    assign i_sample_ch.ready         = (r_state == ST_IDLE);
    assign accept                    = i_sample_ch.valid && i_sample_ch.ready;
    assign take_out                  = r_ovalid && o_result_ch.ready;
    assign load_out                  = (r_state == ST_DECIDE) && (!r_ovalid || o_result_ch.ready);
    assign o_result_ch.valid         = r_ovalid;
    assign o_result_ch.speech_active = r_ospeech;
    assign o_result_ch.frame_level   = r_olevel;
    assign o_result_ch.state_flipped = r_oflip;

    always_comb begin
        abs_s      = r_sample[15] ? 17'd0 - {r_sample[15], r_sample} : {1'b0, r_sample};
        sum_new    = r_sum + prod[SUM_W-1:0];
        cnt_new    = r_cnt + CNT_W'(1);
        frame_done = r_fend || (32'(cnt_new) >= 32'(MAX_FRAME_SAMPLES));
        lg_cur     = {r_e, r_frac};
        d_val      = $signed(D_W'(r_lga)) - $signed(D_W'(lg_cur)) - $signed(D_W'(LG_OFFSET));
        d_neg      = d_val[D_W-1] ? D_W'(0) - d_val : '0;
        rounded    = prod + ROUND_HALF;
        mag        = rounded[63:24];
        unique case (r_state)
            ST_SQUARE: begin
                mul_a = MUL_W'(abs_s);
                mul_b = MUL_W'(abs_s);
            end
            ST_FMUL: begin
                mul_a = MUL_W'(r_m);
                mul_b = MUL_W'(r_m);
            end
            default: begin
                mul_a = r_t;
                mul_b = TEN_LOG10_2_Q16;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (accept) n_state = ST_SQUARE;
            ST_SQUARE:  n_state = ST_ACCUM;
            ST_ACCUM: begin
                if (!frame_done) begin
                    n_state = ST_IDLE;
                end else if (sum_new == '0) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_state = ST_NORM;
                end
            end
            ST_NORM:    if (r_x[SUM_W-1]) n_state = ST_FMUL;
            ST_FMUL:    n_state = ST_FSTEP;
            ST_FSTEP:   n_state = (r_it == 4'd15) ? ST_LOGDONE : ST_FMUL;
            ST_LOGDONE: n_state = r_pass ? ST_SCALE : ST_NORM;
            ST_SCALE:   n_state = ST_ROUND;
            ST_ROUND:   n_state = ST_DECIDE;
            ST_DECIDE:  if (load_out) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pend   <= 1'b0;
            r_sum    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && i_sample_ch.discontinuity) begin
                r_pend <= 1'b1;
            end else if (load_out) begin
                r_pend <= 1'b0;
            end
            if (r_state == ST_ACCUM) begin
                r_sum <= frame_done ? '0 : sum_new;
                r_cnt <= frame_done ? '0 : cnt_new;
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (take_out) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_sample_ch.sample;
            r_fend   <= i_sample_ch.frame_end;
        end
        if (load_out) begin
            r_ospeech <= dec.speech;
            r_oflip   <= dec.flipped;
            r_olevel  <= r_level;
        end
        unique case (r_state)
            ST_ACCUM: begin
                r_x     <= sum_new;
                r_n     <= cnt_new;
                r_k     <= '0;
                r_pass  <= 1'b0;
                r_level <= LVL_FLOOR;
            end
            ST_NORM: begin
                if (r_x[SUM_W-1]) begin
                    r_m    <= r_x[SUM_W-1 -: MANT_W];
                    r_e    <= K_W'(SUM_W - 1) - r_k;
                    r_frac <= '0;
                    r_it   <= '0;
                end else begin
                    r_x <= {r_x[SUM_W-2:0], 1'b0};
                    r_k <= r_k + K_W'(1);
                end
            end
            ST_FSTEP: begin
                r_it <= r_it + 4'd1;
                if (prod[61]) begin
                    r_frac <= {r_frac[FRAC_W-2:0], 1'b1};
                    r_m    <= prod[61:31];
                end else begin
                    r_frac <= {r_frac[FRAC_W-2:0], 1'b0};
                    r_m    <= prod[60:30];
                end
            end
            ST_LOGDONE: begin
                if (!r_pass) begin
                    r_lga  <= lg_cur;
                    r_x    <= SUM_W'(r_n);
                    r_k    <= '0;
                    r_pass <= 1'b1;
                end else begin
                    r_t <= MUL_W'(d_neg);
                end
            end
            ST_ROUND: begin
                r_level <= (mag > LVL_FLOOR_MAG) ? LVL_FLOOR : 16'd0 - mag[15:0];
            end
            default: ;
        endcase
    end

endmodule
